>>> hw/rtl/mfp_pkg.sv
// mfp_pkg: shared types and constants for the mixed fraction text parser
// used by mfp_ctrl, mfp_dp, the top level and the checker; no dependencies
package mfp_pkg;

   localparam int MAX_CHARS_DEF  = 19;
   localparam int VALUE_BITS_DEF = 32;

   // working width of magnitude, gcd and divider
   localparam int MAG_W = 64;
   localparam int OUT_W = 31;
   localparam logic [MAG_W-1:0] OUT_MAX = MAG_W'(32'h7FFF_FFFF);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [1:0] PH_WHOLE  = 2'd0;
   localparam logic [1:0] PH_TOP    = 2'd1;
   localparam logic [1:0] PH_BOTTOM = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
   localparam logic [1:0] STAT_SAT      = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_MULEND,
      S_GCD,
      S_DIVN,
      S_NEXT,
      S_DIVD,
      S_STORE,
      S_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0]  numer;
      logic [OUT_W-1:0]    denom;
      logic [1:0]          status;
   } rsp_beat_type;

   typedef struct packed {
      logic take;
      logic clear;
      logic set_err;
      logic load_int;
      logic mul_start;
      logic mul_step;
      logic mul_finish;
      logic gcd_step;
      logic div_start_n;
      logic div_start_d;
      logic div_step;
      logic store_n;
      logic store_d;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_int;
      logic zero_den;
      logic mul_last;
      logic gcd_done;
      logic div_last;
   } sts_type;

endpackage

>>> hw/rtl/mfp_dp.sv
// mfp_dp: datapath of the parser; digit accumulators, shift-add multiplier,
// binary gcd, restoring divider and the result register; uses mfp_pkg
module mfp_dp #(
   parameter int MAX_CHARS  = mfp_pkg::MAX_CHARS_DEF,
   parameter int VALUE_BITS = mfp_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mfp_pkg::req_beat_type req_beat,
   input  mfp_pkg::cmd_type      cmd,
   output mfp_pkg::sts_type      sts,
   output mfp_pkg::rsp_beat_type rsp_beat
);
   import mfp_pkg::*;

   localparam int FW    = VALUE_BITS - 1;
   localparam int PW    = 2 * FW;
   localparam int SUM_W = PW + 1;
   localparam int CW    = $clog2(MAX_CHARS + 1);
   localparam int CNT_W = $clog2(MAG_W);
   localparam int KW    = $clog2(MAG_W) + 1;

   // line state
   logic [FW-1:0] whole_ff, whole_in, top_ff, top_in, bottom_ff, bottom_in;
   logic [1:0]    phase_ff, phase_in;
   logic          neg_ff, neg_in, sat_ff, sat_in, err_ff, err_in;
   logic [CW-1:0] count_ff, count_in;

   // arithmetic registers
   logic [MAG_W-1:0] mag_ff, mag_in, den_ff, den_in;
   logic [MAG_W-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [PW-1:0]    p_ff, p_in, mc_ff, mc_in;
   logic [FW-1:0]    mp_ff, mp_in;
   logic [MAG_W-1:0] q_ff, q_in, r_ff, r_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_beat_type     rsp_ff, rsp_in;

   logic [FW-1:0]    acc_cur;
   logic [FW+3:0]    acc_ext;
   logic [FW-1:0]    acc_new;
   logic             acc_sat;
   logic [3:0]       digit;
   logic             is_digit;
   logic [SUM_W-1:0] sum;
   logic [MAG_W-1:0] sum_sat;
   logic [MAG_W:0]   rs;
   logic [MAG_W-1:0] gdiff;
   logic             mag_big, den_big;
   logic [OUT_W-1:0] m31, d31;
   logic [31:0]      m32;

   assign digit    = 4'(req_beat.ch - CH_ZERO);
   assign is_digit = (req_beat.ch >= CH_ZERO) && (req_beat.ch <= CH_NINE);

   always_comb begin
      priority if (phase_ff == PH_WHOLE) acc_cur = whole_ff;
      else if (phase_ff == PH_TOP)       acc_cur = top_ff;
      else                               acc_cur = bottom_ff;
   end

   // acc*10 + d, saturating at the field maximum
   assign acc_ext = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1) + (FW+4)'(digit);
   assign acc_sat = |acc_ext[FW+3:FW];
   assign acc_new = acc_sat ? '1 : acc_ext[FW-1:0];

   assign sum = SUM_W'(p_ff) + SUM_W'(top_ff);
   generate
      if (SUM_W > MAG_W) begin : g_sat
         assign sum_sat = (|sum[SUM_W-1:MAG_W]) ? '1 : sum[MAG_W-1:0];
      end else begin : g_nosat
         assign sum_sat = MAG_W'(sum);
      end
   endgenerate

   assign rs    = {r_ff, q_ff[MAG_W-1]};
   assign gdiff = (ga_ff >= gb_ff) ? ga_ff - gb_ff : gb_ff - ga_ff;

   always_comb begin
      whole_in  = whole_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      sat_in    = sat_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      mag_in    = mag_ff;
      den_in    = den_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      mc_in     = mc_ff;
      mp_in     = mp_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;

      if (cmd.take && (count_ff < CW'(MAX_CHARS))) begin
         count_in = count_ff + 1'b1;
         priority if (is_digit) begin
            if (acc_sat) sat_in = 1'b1;
            priority if (phase_ff == PH_WHOLE) whole_in = acc_new;
            else if (phase_ff == PH_TOP)       top_in = acc_new;
            else                               bottom_in = acc_new;
         end else if (req_beat.ch == CH_MINUS) begin
            if (count_ff == '0) neg_in = 1'b1;
         end else if (req_beat.ch == CH_SPACE) begin
            if (phase_ff == PH_WHOLE) phase_in = PH_TOP;
         end else if (req_beat.ch == CH_SLASH) begin
            if (phase_ff == PH_WHOLE) begin
               top_in   = whole_ff;
               whole_in = '0;
               phase_in = PH_BOTTOM;
            end else if (phase_ff == PH_TOP) begin
               phase_in = PH_BOTTOM;
            end
         end else begin
            phase_in = phase_ff;
         end
      end

      if (cmd.set_err) err_in = 1'b1;

      if (cmd.load_int) begin
         mag_in = MAG_W'(whole_ff);
         den_in = MAG_W'(1);
         ga_in  = MAG_W'(whole_ff);
         gb_in  = MAG_W'(1);
         k_in   = '0;
      end

      if (cmd.mul_start) begin
         p_in   = '0;
         mc_in  = PW'(whole_ff);
         mp_in  = bottom_ff;
         cnt_in = '0;
      end
      if (cmd.mul_step) begin
         if (mp_ff[0]) p_in = p_ff + mc_ff;
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.mul_finish) begin
         mag_in = sum_sat;
         den_in = MAG_W'(bottom_ff);
         ga_in  = sum_sat;
         gb_in  = MAG_W'(bottom_ff);
         k_in   = '0;
      end

      // one binary gcd step
      if (cmd.gcd_step && (ga_ff != '0)) begin
         priority if (!ga_ff[0] && !gb_ff[0]) begin
            ga_in = ga_ff >> 1;
            gb_in = gb_ff >> 1;
            k_in  = k_ff + 1'b1;
         end else if (!ga_ff[0]) begin
            ga_in = ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_in = gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_in = gdiff >> 1;
         end else begin
            gb_in = gdiff >> 1;
         end
      end

      if (cmd.div_start_n) begin
         q_in   = mag_ff;
         r_in   = '0;
         dvs_in = gb_ff << k_ff;
         cnt_in = '0;
      end
      if (cmd.store_n) mag_in = q_ff;
      if (cmd.div_start_d) begin
         q_in   = den_ff;
         r_in   = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (rs >= {1'b0, dvs_ff}) begin
            r_in = MAG_W'(rs - {1'b0, dvs_ff});
            q_in = {q_ff[MAG_W-2:0], 1'b1};
         end else begin
            r_in = rs[MAG_W-1:0];
            q_in = {q_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.store_d) den_in = q_ff;

      if (cmd.emit) begin
         if (err_ff) begin
            rsp_in.numer  = '0;
            rsp_in.denom  = '0;
            rsp_in.status = STAT_ZERO_DEN;
         end else begin
            rsp_in.numer  = neg_ff ? -m32 : m32;
            rsp_in.denom  = d31;
            rsp_in.status = (sat_ff || mag_big || den_big) ? STAT_SAT : STAT_OK;
         end
      end

      if (cmd.clear) begin
         whole_in  = '0;
         top_in    = '0;
         bottom_in = '0;
         phase_in  = PH_WHOLE;
         neg_in    = 1'b0;
         sat_in    = 1'b0;
         err_in    = 1'b0;
         count_in  = '0;
      end
   end

   // clamp to the 31-bit result range
   assign mag_big = mag_ff > OUT_MAX;
   assign den_big = (mag_ff != '0) && (den_ff > OUT_MAX);
   assign m31     = mag_big ? OUT_MAX[OUT_W-1:0] : mag_ff[OUT_W-1:0];
   assign m32     = {1'b0, m31};
   always_comb begin
      priority if (mag_ff == '0) d31 = OUT_W'(1);
      else if (den_big)          d31 = OUT_MAX[OUT_W-1:0];
      else                       d31 = den_ff[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         phase_ff  <= PH_WHOLE;
         neg_ff    <= 1'b0;
         sat_ff    <= 1'b0;
         err_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         whole_ff  <= whole_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         sat_ff    <= sat_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      den_ff <= den_in;
      ga_ff  <= ga_in;
      gb_ff  <= gb_in;
      k_ff   <= k_in;
      p_ff   <= p_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign sts.is_int   = (phase_ff == PH_WHOLE);
   assign sts.zero_den = (phase_ff == PH_TOP) || (bottom_ff == '0);
   assign sts.mul_last = (cnt_ff == CNT_W'(FW - 1));
   assign sts.gcd_done = (ga_ff == '0);
   assign sts.div_last = (cnt_ff == CNT_W'(MAG_W - 1));
   assign rsp_beat     = rsp_ff;

endmodule

>>> hw/rtl/mfp_ctrl.sv
// mfp_ctrl: sequencer of the parser; drives datapath commands and both
// handshakes; uses mfp_pkg
module mfp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  mfp_pkg::sts_type sts,
   output mfp_pkg::cmd_type cmd
);
   import mfp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (sts.is_int) begin
               cmd.load_int = 1'b1;
               state_in     = S_GCD;
            end else if (sts.zero_den) begin
               cmd.set_err = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_last) state_in = S_MULEND;
         end
         S_MULEND: begin
            cmd.mul_finish = 1'b1;
            state_in       = S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_start_n = 1'b1;
               state_in        = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.store_n     = 1'b1;
            cmd.div_start_d = 1'b1;
            state_in        = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store_d = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/mixed_fraction_text_parser.sv
// mixed_fraction_text_parser: top level, one line of text in, one reduced
// fraction out; depends on mfp_pkg, mfp_ctrl and mfp_dp
// a character that is not last is taken back to back
// a last character starts the line end work: evaluate, a shift-add multiply
// (fractions only), binary gcd steps, then two bit-serial divisions and the
// result store and emit; a zero denominator goes straight to emit
// synchronous active-high reset clears the line state and the result valid
module mixed_fraction_text_parser #(
   parameter int MAX_CHARS  = mfp_pkg::MAX_CHARS_DEF,
   parameter int VALUE_BITS = mfp_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // character beats
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mfp_pkg::req_beat_type req_beat,
   // result beats
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mfp_pkg::rsp_beat_type rsp_beat
);
   import mfp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns both handshakes, the result valid flag and the
   // order of multiply, gcd and the two divisions
   mfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_beat.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: digit fields, arithmetic units and the result register,
   // which holds a finished beat while the next line's characters arrive
   mfp_dp #(
      .MAX_CHARS  (MAX_CHARS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_beat (req_beat),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_beat (rsp_beat)
   );

endmodule

>>> hw/rtl/mfp_chk.sv
// mfp_chk: port-level checks for the parser, bound to the top level
// depends on mfp_pkg
module mfp_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input mfp_pkg::req_beat_type req_beat,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input mfp_pkg::rsp_beat_type rsp_beat
);
   import mfp_pkg::*;

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   // no result straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // end of line puts the block busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_beat.last |=> req_stall)
      else $error("input taken during line end work");

   // zero denominator beats carry a zero fraction
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.status == STAT_ZERO_DEN |->
         rsp_beat.numer == 0 && rsp_beat.denom == 0)
      else $error("zero denominator beat with value");

   // good results never have a zero denominator
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.status == STAT_OK |-> rsp_beat.denom != 0)
      else $error("ok beat with zero denominator");

endmodule

bind mixed_fraction_text_parser mfp_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_beat  (req_beat),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);
